>>> hdl/id_allocator_with_preference_macros.svh
// Assertion macros for the identifier allocator checker.
// Expects clk and arst_n in the scope of each use.
`ifndef ID_ALLOCATOR_WITH_PREFERENCE_MACROS_SVH
`define ID_ALLOCATOR_WITH_PREFERENCE_MACROS_SVH

// same-cycle implication, checked outside reset
`define IDAP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator port check failed");

// next-cycle implication, checked outside reset
`define IDAP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator port check failed");

`endif

>>> hdl/idap_pkg.sv
// Shared constants, types and helper functions of the identifier allocator.
// No dependencies; used by the map memory, the top level and the checker.
package idap_pkg;

	localparam int ID_COUNT = 256;
	localparam int ID_LIMIT = (ID_COUNT < 256) ? ID_COUNT : 256;
	localparam int ID_W     = 8;
	localparam int SCAN_START = 2;

	// used map is held as words of WORD_W marks
	localparam int WORD_W = (ID_LIMIT < 32) ? (2 ** $clog2(ID_LIMIT)) : 32;
	localparam int WBITS  = $clog2(WORD_W);
	localparam int WORDS  = (ID_LIMIT + WORD_W - 1) / WORD_W;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_PREFERRED = 2'd0;
	localparam logic [1:0] ST_OTHER     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_RELEASED  = 2'd3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [AW-1:0]     waddr_t;

	typedef struct packed {
		logic   rd;
		waddr_t raddr;
		logic   wr;
		waddr_t waddr;
		word_t  wdata;
	} mem_req_t;

	typedef struct packed {
		logic             found;
		logic [WBITS-1:0] idx;
	} find_t;

	// word holding an identifier; out-of-range words fold to word 0
	function automatic waddr_t word_of(input logic [ID_W-1:0] id);
		logic [ID_W-1:0] w;
		w = id >> WBITS;
		if (int'(w) < WORDS)
			return w[AW-1:0];
		return '0;
	endfunction

	// marks of a word that belong to real identifiers
	function automatic word_t range_mask(input waddr_t a);
		word_t m;
		for (int b = 0; b < WORD_W; b++)
			m[b] = (int'(a) * WORD_W + b) < ID_LIMIT;
		return m;
	endfunction

	// lowest set bit of a word
	function automatic find_t find_first(input word_t v);
		find_t f;
		f = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (v[b]) begin
				f.found = 1'b1;
				f.idx   = WBITS'(b);
			end
		end
		return f;
	endfunction

endpackage

>>> hdl/idap_mem.sv
// Used-map word memory with registered read.
// Per-word valid flops make unwritten words read as all free. Uses idap_pkg.
module idap_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  idap_pkg::mem_req_t req,
	output idap_pkg::word_t    rdata
);

	idap_pkg::word_t mem [idap_pkg::WORDS];
	idap_pkg::word_t raw_q;
	logic [idap_pkg::WORDS-1:0] vld_q;
	logic rv_q;

	always_ff @(posedge clk) begin
		if (req.rd)
			raw_q <= mem[req.raddr];
		if (req.wr)
			mem[req.waddr] <= req.wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rv_q  <= 1'b0;
		end else begin
			if (req.wr)
				vld_q[req.waddr] <= 1'b1;
			if (req.rd)
				rv_q <= vld_q[req.raddr];
		end
	end

	assign rdata = rv_q ? raw_q : '0;

endmodule

>>> hdl/id_allocator_with_preference.sv
// Identifier allocator with preferred identifier, top level.
// Depends on idap_pkg and idap_mem (word-wide used map).
//
//   channel  valid      ready      payload
//   request  req_valid  req_ready  opcode, requested_id
//   result   rsp_valid  rsp_ready  granted_id, status
//
// One item at a time: accept, read the preferred word (S_PREF), then scan the
// map words in turn from the pointer word up to the last word (S_SCAN), then
// load the result register (S_OUT); a release or preferred grant skips the scan.
// The map has 8 words of 32 marks. The map memory read port sets the pace.
// Reset empties the map at once through per-word valid flops; no clearing pass.
// A result stalled by rsp_ready holds the block before it takes the next item.
module id_allocator_with_preference (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic       opcode,
	input  logic [7:0] requested_id,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] granted_id,
	output logic [1:0] status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREF = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q;
	logic       op_q;
	logic [idap_pkg::ID_W-1:0] req_q;
	logic [idap_pkg::ID_W-1:0] ptr_q;
	idap_pkg::waddr_t scan_addr_q;
	logic       first_q;
	logic [idap_pkg::ID_W-1:0] res_id_q;
	logic [1:0] res_st_q;
	logic       rsp_valid_q;
	logic [idap_pkg::ID_W-1:0] out_id_q;
	logic [1:0] out_st_q;

	idap_pkg::mem_req_t mreq;
	idap_pkg::word_t    rdata;

	idap_pkg::waddr_t req_word;
	logic [idap_pkg::WBITS-1:0] req_bit;
	logic       req_in_range;
	idap_pkg::word_t free_w;
	idap_pkg::word_t low_mask;
	idap_pkg::find_t hit;
	logic [idap_pkg::ID_W-1:0] hit_id;
	logic       accept;
	logic       out_free;

	idap_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rdata  (rdata)
	);

	assign accept   = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);

	assign req_word     = idap_pkg::word_of(req_q);
	assign req_bit      = req_q[idap_pkg::WBITS-1:0];
	assign req_in_range = int'(req_q) < idap_pkg::ID_LIMIT;

	// first scanned word only looks at marks at or above the pointer
	assign low_mask = first_q
		? ~((idap_pkg::WORD_W'(1) << ptr_q[idap_pkg::WBITS-1:0]) - idap_pkg::WORD_W'(1))
		: '1;
	assign free_w = ~rdata & idap_pkg::range_mask(scan_addr_q) & low_mask;
	assign hit    = idap_pkg::find_first(free_w);
	assign hit_id = idap_pkg::ID_W'({scan_addr_q, hit.idx});

	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_IDLE: begin
				mreq.rd    = accept;
				mreq.raddr = idap_pkg::word_of(requested_id);
			end
			S_PREF: begin
				mreq.waddr = req_word;
				if (op_q == idap_pkg::OP_RELEASE) begin
					mreq.wr    = req_in_range;
					mreq.wdata = rdata & ~(idap_pkg::WORD_W'(1) << req_bit);
				end else if (req_in_range && !rdata[req_bit]) begin
					mreq.wr    = 1'b1;
					mreq.wdata = rdata | (idap_pkg::WORD_W'(1) << req_bit);
				end else begin
					mreq.rd    = 1'b1;
					mreq.raddr = idap_pkg::word_of(ptr_q);
				end
			end
			S_SCAN: begin
				mreq.waddr = scan_addr_q;
				mreq.wdata = rdata | (idap_pkg::WORD_W'(1) << hit.idx);
				mreq.raddr = scan_addr_q + idap_pkg::AW'(1);
				if (hit.found)
					mreq.wr = 1'b1;
				else if (int'(scan_addr_q) != idap_pkg::WORDS - 1)
					mreq.rd = 1'b1;
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= idap_pkg::ID_W'(idap_pkg::SCAN_START);
			rsp_valid_q <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			// load a new result or drop the one just taken
			if (state_q == S_OUT && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept)
						state_q <= S_PREF;
				end
				S_PREF: begin
					if (op_q == idap_pkg::OP_RELEASE ||
					    (req_in_range && !rdata[req_bit])) begin
						state_q <= S_OUT;
					end else begin
						first_q <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					first_q <= 1'b0;
					if (hit.found) begin
						ptr_q   <= hit_id;
						state_q <= S_OUT;
					end else if (int'(scan_addr_q) == idap_pkg::WORDS - 1) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			req_q <= requested_id;
		end
		if (state_q == S_PREF) begin
			scan_addr_q <= idap_pkg::word_of(ptr_q);
			res_id_q    <= req_q;
			res_st_q    <= (op_q == idap_pkg::OP_RELEASE) ? idap_pkg::ST_RELEASED
			                                              : idap_pkg::ST_PREFERRED;
		end
		if (state_q == S_SCAN) begin
			scan_addr_q <= scan_addr_q + idap_pkg::AW'(1);
			if (hit.found) begin
				res_id_q <= hit_id;
				res_st_q <= idap_pkg::ST_OTHER;
			end else begin
				res_id_q <= '0;
				res_st_q <= idap_pkg::ST_FULL;
			end
		end
		if (state_q == S_OUT && out_free) begin
			out_id_q <= res_id_q;
			out_st_q <= res_st_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign granted_id = out_id_q;
	assign status     = out_st_q;

endmodule

>>> hdl/idap_chk.sv
// Port-level checker for the identifier allocator, bound to the top level.
// Uses idap_pkg and the assertion macros header.
`include "id_allocator_with_preference_macros.svh"

module idap_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] granted_id,
	input logic [1:0] status
);

	// a stalled result holds
	`IDAP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(granted_id) && $stable(status))
	// one item in flight: no accept right after an accept
	`IDAP_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)
	// full reports identifier zero
	`IDAP_ASSERT_NOW(a_full_zero, rsp_valid && status == idap_pkg::ST_FULL, granted_id == 8'd0)
	// scan never grants below the start of the pointer
	`IDAP_ASSERT_NOW(a_scan_floor, rsp_valid && status == idap_pkg::ST_OTHER, granted_id >= 8'(idap_pkg::SCAN_START))

endmodule

bind id_allocator_with_preference idap_chk u_idap_chk (.*);
